/* src/lbpg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lbpg_pkg;

    localparam int TIME_W = 32;
    localparam int IDX_W  = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // led modes
    localparam logic [1:0] MODE_STATIC  = 2'd0;
    localparam logic [1:0] MODE_ONOFF   = 2'd1;
    localparam logic [1:0] MODE_PATTERN = 2'd2;

    // pattern length codes
    localparam logic [1:0] LEN_8  = 2'd0;
    localparam logic [1:0] LEN_16 = 2'd1;
    localparam logic [1:0] LEN_32 = 2'd2;

    // input kinds
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // register map
    localparam logic [CFG_INDEX_W-1:0] REG_MODE           = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STATIC_LEVEL   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_TIME        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_TIME       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_TIME       = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERSE        = 3'd7;

    localparam logic [TIME_W-1:0] PHASE_TIME_RESET = 32'd1000;

    // index mask for the used part of the pattern word
    function automatic logic [IDX_W-1:0] len_mask(input logic [1:0] len);
        logic [IDX_W-1:0] m;
        case (len)
            LEN_8:   m = 5'd7;
            LEN_16:  m = 5'd15;
            default: m = 5'd31;
        endcase
        return m;
    endfunction

    // most significant used bit first
    function automatic logic pattern_bit(input logic [31:0] word,
                                         input logic [IDX_W-1:0] mask,
                                         input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] sh;
        sh = mask - (idx & mask);
        return word[sh];
    endfunction

endpackage

`default_nettype wire

/* src/led_blink_pattern_generator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// an accepted input beat is held in the input register, and its result is registered into the
// output register that drives m_tvalid
// throughput: one item per cycle while the output is not stalled, set by the state update stage
// while a result waits on m_tready the input register takes one more beat, then holds off
// reset: synchronous, active low; clears the led state and loads the register defaults

module led_blink_pattern_generator_unit
    import lbpg_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [31:0]            s_tdata,   // [31:0] now_ms
    input  wire logic                   s_tuser,   // [0] op
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,   // [0] pin_level, [1] changed, [7:2] zero
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [1:0]        mode_reg;
    logic              static_level_reg;
    logic [TIME_W-1:0] on_time_reg;
    logic [TIME_W-1:0] off_time_reg;
    logic [31:0]       pattern_word_reg;
    logic [1:0]        pattern_length_reg;
    logic [TIME_W-1:0] bit_time_reg;
    logic              inverse_reg;

    logic              in_valid_reg, in_valid_next;
    logic              in_op_reg;
    logic [TIME_W-1:0] in_now_reg;

    logic              lit_reg, lit_next;
    logic [TIME_W-1:0] last_change_reg, last_change_next;
    logic [IDX_W-1:0]  bit_index_reg, bit_index_next;

    logic              m_valid_reg, m_valid_next;
    logic              pin_reg, pin_next;
    logic              changed_reg, changed_next;

    logic              advance;
    logic              s_accept;
    logic              work;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] limit;
    logic [IDX_W-1:0]  mask;
    logic [IDX_W-1:0]  idx_inc;
    logic              lit_new;
    logic [IDX_W-1:0]  idx_new;
    logic              chg;

    assign cfg_ready = 1'b1;
    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign work      = in_valid_reg && advance;

    assign elapsed = in_now_reg - last_change_reg;
    assign limit   = lit_reg ? on_time_reg : off_time_reg;
    assign mask    = len_mask(pattern_length_reg);
    assign idx_inc = (bit_index_reg + 5'd1) & mask;

    always_comb begin
        lit_new = lit_reg;
        idx_new = bit_index_reg;
        chg     = 1'b0;
        if (in_op_reg == OP_START) begin
            chg = 1'b1;
            case (mode_reg)
                MODE_ONOFF: lit_new = 1'b1;
                MODE_PATTERN: begin
                    idx_new = '0;
                    lit_new = pattern_bit(pattern_word_reg, mask, '0);
                end
                default: lit_new = static_level_reg;
            endcase
        end else begin
            case (mode_reg)
                MODE_ONOFF: begin
                    if (elapsed >= limit) begin
                        lit_new = !lit_reg;
                        chg     = 1'b1;
                    end
                end
                MODE_PATTERN: begin
                    if (elapsed >= bit_time_reg) begin
                        idx_new = idx_inc;
                        lit_new = pattern_bit(pattern_word_reg, mask, idx_inc);
                        chg     = 1'b1;
                    end
                end
                default: begin
                    if (lit_reg != static_level_reg) begin
                        lit_new = static_level_reg;
                        chg     = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb begin
        in_valid_next    = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        lit_next         = work ? lit_new : lit_reg;
        bit_index_next   = work ? idx_new : bit_index_reg;
        last_change_next = (work && chg) ? in_now_reg : last_change_reg;
        m_valid_next     = advance ? in_valid_reg : m_valid_reg;
        pin_next         = work ? (lit_new ^ inverse_reg) : pin_reg;
        changed_next     = work ? chg : changed_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            lit_reg         <= 1'b0;
            last_change_reg <= '0;
            bit_index_reg   <= '0;
        end else begin
            in_valid_reg    <= in_valid_next;
            m_valid_reg     <= m_valid_next;
            lit_reg         <= lit_next;
            last_change_reg <= last_change_next;
            bit_index_reg   <= bit_index_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg  <= s_tuser;
            in_now_reg <= s_tdata;
        end
        pin_reg     <= pin_next;
        changed_reg <= changed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= MODE_STATIC;
            static_level_reg   <= 1'b0;
            on_time_reg        <= PHASE_TIME_RESET;
            off_time_reg       <= PHASE_TIME_RESET;
            pattern_word_reg   <= '0;
            pattern_length_reg <= LEN_32;
            bit_time_reg       <= '0;
            inverse_reg        <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MODE:           mode_reg           <= cfg_data[1:0];
                REG_STATIC_LEVEL:   static_level_reg   <= cfg_data[0];
                REG_ON_TIME:        on_time_reg        <= cfg_data;
                REG_OFF_TIME:       off_time_reg       <= cfg_data;
                REG_PATTERN_WORD:   pattern_word_reg   <= cfg_data;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[1:0];
                REG_BIT_TIME:       bit_time_reg       <= cfg_data;
                REG_INVERSE:        inverse_reg        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, changed_reg, pin_reg};

endmodule

`default_nettype wire

/* src/lbpg_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module lbpg_assertions
    import lbpg_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tuser,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // no result beat straight out of reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // an empty output side never holds off the input
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // a start beat taken while the output is empty yields a result beat that reports a change
    a_start_changes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_START && !m_tvalid) ##1 m_tready
        |=> (m_tvalid && m_tdata[1]))
        else $error("start beat did not report a change");

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed");

endmodule

bind led_blink_pattern_generator_unit lbpg_assertions u_lbpg_assertions (.*);

`default_nettype wire
